### rtl/core/cpl_pkg.sv
// Package for the ChordPro byte lexer: character classes, token codes,
// the state transition table and the result type. No dependencies.
package cpl_pkg;

    localparam int NUM_STATES  = 10;
    localparam int NUM_CLASSES = 10;

    typedef logic [3:0] state_t;
    typedef logic [3:0] class_t;
    typedef logic [6:0] code_t;
    typedef logic [2:0] kind_t;

    // Character classes
    localparam class_t CLS_SPACE  = 4'd0;
    localparam class_t CLS_ALPHA  = 4'd1;
    localparam class_t CLS_DIGIT  = 4'd2;
    localparam class_t CLS_LBRACE = 4'd3;
    localparam class_t CLS_RBRACE = 4'd4;
    localparam class_t CLS_LBRACK = 4'd5;
    localparam class_t CLS_RBRACK = 4'd6;
    localparam class_t CLS_COLON  = 4'd7;
    localparam class_t CLS_END    = 4'd8;
    localparam class_t CLS_NL     = 4'd9;
    localparam class_t CLS_NONE   = 4'd15;

    // Table entries above the state range are token codes
    localparam code_t TOK_CHORD = 7'd101;
    localparam code_t TOK_DIR   = 7'd102;
    localparam code_t TOK_LYRIC = 7'd103;
    localparam code_t TOK_END   = 7'd104;
    localparam code_t TOK_NEWLN = 7'd105;
    localparam code_t TOK_MIN   = 7'd101;

    localparam state_t ST_START = 4'd0;

    // Result kinds
    localparam kind_t KIND_NONE  = 3'd0;
    localparam kind_t KIND_CHORD = 3'd1;
    localparam kind_t KIND_DIR   = 3'd2;
    localparam kind_t KIND_LYRIC = 3'd3;
    localparam kind_t KIND_DROP  = 3'd4;

    // Rows: state; columns: sp a 0 { } [ ] : end nl
    localparam code_t TRANS [NUM_STATES][NUM_CLASSES] = '{
        '{7'd6, 7'd6, 7'd6, 7'd3, 7'd6, 7'd1, 7'd6, 7'd6, TOK_END, 7'd9},
        '{7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd2, 7'd1, TOK_END, TOK_NEWLN},
        '{TOK_CHORD, TOK_CHORD, TOK_CHORD, TOK_CHORD, TOK_CHORD,
          TOK_CHORD, TOK_CHORD, TOK_CHORD, TOK_CHORD, TOK_CHORD},
        '{7'd3, 7'd3, 7'd3, 7'd3, 7'd3, 7'd3, 7'd3, 7'd4, TOK_END, TOK_NEWLN},
        '{7'd4, 7'd4, 7'd4, 7'd4, 7'd5, 7'd4, 7'd4, 7'd4, TOK_END, TOK_NEWLN},
        '{TOK_DIR, TOK_DIR, TOK_DIR, TOK_DIR, TOK_DIR,
          TOK_DIR, TOK_DIR, TOK_DIR, TOK_DIR, TOK_DIR},
        '{7'd6, 7'd6, 7'd6, TOK_LYRIC, 7'd6, TOK_LYRIC, 7'd6, 7'd6,
          TOK_LYRIC, TOK_LYRIC},
        '{7'd6, 7'd6, 7'd6, 7'd3, 7'd6, 7'd1, 7'd6, 7'd6, TOK_END, 7'd9},
        '{7'd6, 7'd6, 7'd6, 7'd3, 7'd6, 7'd1, 7'd6, 7'd6, TOK_END, 7'd9},
        '{TOK_NEWLN, TOK_NEWLN, TOK_NEWLN, TOK_NEWLN, TOK_NEWLN,
          TOK_NEWLN, TOK_NEWLN, TOK_NEWLN, TOK_END, TOK_NEWLN}
    };

    typedef struct packed {
        kind_t      kind;
        logic       appended;
        logic [7:0] lexeme;
        logic       ended;
        logic       bad;
    } result_t;

    function automatic kind_t kind_of(input code_t code);
        kind_t k;
        unique case (code)
            TOK_CHORD: k = KIND_CHORD;
            TOK_DIR:   k = KIND_DIR;
            TOK_LYRIC: k = KIND_LYRIC;
            TOK_NEWLN: k = KIND_DROP;
            default:   k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

### rtl/core/cpl_classify.sv
// Byte classifier for the ChordPro lexer: maps a character to its class.
// Depends on cpl_pkg.
module cpl_classify (
    input  logic [7:0]      text_byte,
    output cpl_pkg::class_t char_class
);

    always_comb
    begin
        priority if ((text_byte >= "a" && text_byte <= "z") ||
                     (text_byte >= "A" && text_byte <= "Z") || text_byte == ",")
            char_class = cpl_pkg::CLS_ALPHA;
        else if (text_byte >= "0" && text_byte <= "9")
            char_class = cpl_pkg::CLS_DIGIT;
        else if (text_byte == " ")
            char_class = cpl_pkg::CLS_SPACE;
        else if (text_byte == "{")
            char_class = cpl_pkg::CLS_LBRACE;
        else if (text_byte == "}")
            char_class = cpl_pkg::CLS_RBRACE;
        else if (text_byte == "[")
            char_class = cpl_pkg::CLS_LBRACK;
        else if (text_byte == "]")
            char_class = cpl_pkg::CLS_RBRACK;
        else if (text_byte == ":")
            char_class = cpl_pkg::CLS_COLON;
        else if (text_byte == 8'h0a)
            char_class = cpl_pkg::CLS_NL;
        else
            char_class = cpl_pkg::CLS_NONE;
    end

endmodule

### rtl/core/cpl_step.sv
// Scanner state register and one-step transition logic, including the
// same-cycle reprocess from the start state. Depends on cpl_pkg.
module cpl_step (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [7:0]        text_byte,
    input  logic              stream_end,
    input  cpl_pkg::class_t   char_class,
    output cpl_pkg::result_t  result
);

    cpl_pkg::state_t state_reg;
    cpl_pkg::state_t state_next;
    cpl_pkg::state_t cur_state;
    cpl_pkg::code_t  code;
    cpl_pkg::code_t  restart_code;

    // Unreachable rows fall back to start
    always_comb
    begin
        if (state_reg > 4'd9 || state_reg == 4'd7 || state_reg == 4'd8)
            cur_state = cpl_pkg::ST_START;
        else
            cur_state = state_reg;
    end

    always_comb
    begin
        result       = '0;
        state_next   = state_reg;
        code         = '0;
        restart_code = '0;
        if (stream_end)
        begin
            code = cpl_pkg::TRANS[cur_state][cpl_pkg::CLS_END];
            if (code == cpl_pkg::TOK_END)
                result.kind = (cur_state != cpl_pkg::ST_START) ?
                              cpl_pkg::KIND_DROP : cpl_pkg::KIND_NONE;
            else
                result.kind = cpl_pkg::kind_of(code);
            result.ended = 1'b1;
            state_next   = cpl_pkg::ST_START;
        end
        else if (char_class == cpl_pkg::CLS_NONE)
        begin
            result.bad = 1'b1;
        end
        else
        begin
            code         = cpl_pkg::TRANS[cur_state][char_class];
            restart_code = cpl_pkg::TRANS[cpl_pkg::ST_START][char_class];
            // Token done: reprocess this byte from start in the same step
            if (code >= cpl_pkg::TOK_MIN)
            begin
                result.kind = cpl_pkg::kind_of(code);
                state_next  = restart_code[3:0];
            end
            else
            begin
                state_next = code[3:0];
            end
            result.appended = 1'b1;
            result.lexeme   = text_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= cpl_pkg::ST_START;
        else if (advance)
            state_reg <= state_next;
    end

endmodule

### rtl/core/chordpro_lexer.sv
// ChordPro byte lexer: one byte enters on s_t* and one result leaves on m_t*
// per transaction. It accepts a new byte every cycle while the result side is
// not stalled; each byte passes through the input register and then the result
// register, with the class lookup, the table step and any restart from the
// start state in the single combinational path between them. Depends on
// cpl_pkg, cpl_classify and cpl_step.
module chordpro_lexer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // stream_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [2:0] finished_kind, [3] appended,
                                   // [11:4] lexeme_byte, [15:12] zero
    output logic        m_tlast,   // input_ended
    output logic        m_tuser    // bad_byte
);

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_end_reg;
    logic             out_valid_reg;
    cpl_pkg::result_t out_reg;
    cpl_pkg::result_t step_result;
    cpl_pkg::class_t  char_class;
    logic             out_free;
    logic             advance;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (out_free)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
        if (advance)
            out_reg <= step_result;
    end

    cpl_classify u_classify (
        .text_byte  (in_byte_reg),
        .char_class (char_class)
    );

    cpl_step u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .text_byte  (in_byte_reg),
        .stream_end (in_end_reg),
        .char_class (char_class),
        .result     (step_result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_reg.lexeme, out_reg.appended, out_reg.kind};
    assign m_tlast  = out_reg.ended;
    assign m_tuser  = out_reg.bad;

`ifndef ASSERT_OFF
    a_bad_not_appended: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> !m_tdata[3] && m_tdata[2:0] == cpl_pkg::KIND_NONE)
        else $error("bad byte result carries a token or lexeme byte");

    a_end_not_appended: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> !m_tdata[3] && !m_tuser)
        else $error("end-of-input result appended a byte or flagged it bad");

    a_lexeme_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[3] |-> m_tdata[11:4] == 8'd0)
        else $error("lexeme byte nonzero without append");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2:0] <= cpl_pkg::KIND_DROP)
        else $error("finished kind out of range");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_free |=> in_valid_reg && $stable(in_byte_reg))
        else $error("input register changed while the result side stalled");
`endif

endmodule

### tb/sv/tb_chordpro_lexer.sv
// Testbench for chordpro_lexer: drives song text bytes on the input stream and checks
// every result against an in-bench lexer model of the token states.
// Depends on cpl_pkg (types, class, token and kind codes) and the chordpro_lexer RTL.
`timescale 1ns / 1ps

module tb_chordpro_lexer;

    // Lexer states tracked by the bench model
    localparam cpl_pkg::state_t LX_START      = 4'd0;
    localparam cpl_pkg::state_t LX_CHORD      = 4'd1;
    localparam cpl_pkg::state_t LX_CHORD_DONE = 4'd2;
    localparam cpl_pkg::state_t LX_DIR_NAME   = 4'd3;
    localparam cpl_pkg::state_t LX_DIR_VALUE  = 4'd4;
    localparam cpl_pkg::state_t LX_DIR_DONE   = 4'd5;
    localparam cpl_pkg::state_t LX_LYRIC      = 4'd6;
    localparam cpl_pkg::state_t LX_NEWLINE    = 4'd9;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] text_byte
    logic        s_tlast  = 1'b0;    // stream_end
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;            // [2:0] finished_kind, [3] appended,
                                     // [11:4] lexeme_byte, [15:12] zero
    logic        m_tlast;            // input_ended
    logic        m_tuser;            // bad_byte

    cpl_pkg::state_t  lex_state = LX_START;
    cpl_pkg::result_t token_results_q[$];
    int unsigned items_sent     = 0;
    int unsigned error_count    = 0;
    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;

    chordpro_lexer DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    function automatic cpl_pkg::class_t lex_class(input logic [7:0] b);
        if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == CH_COMMA)
            return cpl_pkg::CLS_ALPHA;
        if (b >= "0" && b <= "9")
            return cpl_pkg::CLS_DIGIT;
        case (b)
            CH_SPACE:  return cpl_pkg::CLS_SPACE;
            CH_LBRACE: return cpl_pkg::CLS_LBRACE;
            CH_RBRACE: return cpl_pkg::CLS_RBRACE;
            CH_LBRACK: return cpl_pkg::CLS_LBRACK;
            CH_RBRACK: return cpl_pkg::CLS_RBRACK;
            CH_COLON:  return cpl_pkg::CLS_COLON;
            CH_NL:     return cpl_pkg::CLS_NL;
            default:   return cpl_pkg::CLS_NONE;
        endcase
    endfunction

    // Next state for a class, or a token code when the current token completes
    function automatic cpl_pkg::code_t lex_next(input cpl_pkg::state_t s,
                                                input cpl_pkg::class_t c);
        case (s)
            LX_CHORD:
                if (c == cpl_pkg::CLS_RBRACK)   return cpl_pkg::code_t'(LX_CHORD_DONE);
                else if (c == cpl_pkg::CLS_END) return cpl_pkg::TOK_END;
                else if (c == cpl_pkg::CLS_NL)  return cpl_pkg::TOK_NEWLN;
                else                            return cpl_pkg::code_t'(LX_CHORD);
            LX_CHORD_DONE:
                return cpl_pkg::TOK_CHORD;
            LX_DIR_NAME:
                if (c == cpl_pkg::CLS_COLON)    return cpl_pkg::code_t'(LX_DIR_VALUE);
                else if (c == cpl_pkg::CLS_END) return cpl_pkg::TOK_END;
                else if (c == cpl_pkg::CLS_NL)  return cpl_pkg::TOK_NEWLN;
                else                            return cpl_pkg::code_t'(LX_DIR_NAME);
            LX_DIR_VALUE:
                if (c == cpl_pkg::CLS_RBRACE)   return cpl_pkg::code_t'(LX_DIR_DONE);
                else if (c == cpl_pkg::CLS_END) return cpl_pkg::TOK_END;
                else if (c == cpl_pkg::CLS_NL)  return cpl_pkg::TOK_NEWLN;
                else                            return cpl_pkg::code_t'(LX_DIR_VALUE);
            LX_DIR_DONE:
                return cpl_pkg::TOK_DIR;
            LX_LYRIC:
                if (c == cpl_pkg::CLS_LBRACE || c == cpl_pkg::CLS_LBRACK ||
                    c == cpl_pkg::CLS_END || c == cpl_pkg::CLS_NL)
                    return cpl_pkg::TOK_LYRIC;
                else
                    return cpl_pkg::code_t'(LX_LYRIC);
            LX_NEWLINE:
                return (c == cpl_pkg::CLS_END) ? cpl_pkg::TOK_END : cpl_pkg::TOK_NEWLN;
            default:
                if (c == cpl_pkg::CLS_LBRACE)      return cpl_pkg::code_t'(LX_DIR_NAME);
                else if (c == cpl_pkg::CLS_LBRACK) return cpl_pkg::code_t'(LX_CHORD);
                else if (c == cpl_pkg::CLS_END)    return cpl_pkg::TOK_END;
                else if (c == cpl_pkg::CLS_NL)     return cpl_pkg::code_t'(LX_NEWLINE);
                else                               return cpl_pkg::code_t'(LX_LYRIC);
        endcase
    endfunction

    function automatic cpl_pkg::kind_t token_kind(input cpl_pkg::code_t code);
        case (code)
            cpl_pkg::TOK_CHORD: return cpl_pkg::KIND_CHORD;
            cpl_pkg::TOK_DIR:   return cpl_pkg::KIND_DIR;
            cpl_pkg::TOK_LYRIC: return cpl_pkg::KIND_LYRIC;
            cpl_pkg::TOK_NEWLN: return cpl_pkg::KIND_DROP;
            default:            return cpl_pkg::KIND_NONE;
        endcase
    endfunction

    // Advance the model by one input byte and return the result it must produce
    function automatic cpl_pkg::result_t lex_step(input logic [7:0] b, input logic fin);
        cpl_pkg::result_t r;
        cpl_pkg::class_t  c;
        cpl_pkg::code_t   nx;
        r = '0;
        if (fin)
        begin
            nx = lex_next(lex_state, cpl_pkg::CLS_END);
            if (nx == cpl_pkg::TOK_END)
                r.kind = (lex_state != LX_START) ? cpl_pkg::KIND_DROP : cpl_pkg::KIND_NONE;
            else
                r.kind = token_kind(nx);
            r.ended = 1'b1;
            lex_state = LX_START;
        end
        else
        begin
            c = lex_class(b);
            if (c == cpl_pkg::CLS_NONE)
            begin
                r.bad = 1'b1;
            end
            else
            begin
                nx = lex_next(lex_state, c);
                // token done on a byte of the next token: rerun it from start
                if (nx >= cpl_pkg::TOK_MIN)
                begin
                    r.kind = token_kind(nx);
                    nx = lex_next(LX_START, c);
                end
                lex_state = cpl_pkg::state_t'(nx);
                r.appended = 1'b1;
                r.lexeme = b;
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] rand_letter();
        case ($urandom_range(0, 4))
            0:       return 8'("a" + $urandom_range(0, 25));
            1:       return 8'("A" + $urandom_range(0, 25));
            2:       return 8'("0" + $urandom_range(0, 9));
            3:       return CH_SPACE;
            default: return ($urandom_range(0, 1) != 0) ? CH_COMMA : 8'("e");
        endcase
    endfunction

    // Hold the byte on the bus until the transaction completes, then log the prediction
    task automatic send_item(input logic [7:0] b, input logic fin);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        token_results_q.push_back(lex_step(b, fin));
        items_sent++;
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++)
            send_item(text[i], 1'b0);
    endtask

    task automatic test_directed();
        send_text("[Am]");
        send_text("{t:Go}");
        send_text("hi 9,");
        send_text("[C");
        send_item(CH_NL, 1'b0);     // newline inside a chord drops it
        send_item(CH_NL, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);     // not an end marker, just unclassified
        send_item(8'h80, 1'b0);
        send_item(8'hFF, 1'b1);     // end after a pending newline
        send_item(8'h00, 1'b1);     // end from the start state
        send_text("{a");
        send_item(CH_NL, 1'b0);     // newline inside a directive
        send_text("{x:y");
        send_item(8'h5A, 1'b1);     // end with an unfinished directive
    endtask

    // Well-formed song lines with random content
    task automatic test_songs(input int unsigned n_items);
        int unsigned stop_at;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            case ($urandom_range(0, 15))
                0, 1, 2, 3:
                begin
                    send_item(CH_LBRACK, 1'b0);
                    repeat ($urandom_range(1, 4))
                        send_item(rand_letter(), 1'b0);
                    send_item(CH_RBRACK, 1'b0);
                end
                4, 5:
                begin
                    send_item(CH_LBRACE, 1'b0);
                    repeat ($urandom_range(1, 5))
                        send_item(rand_letter(), 1'b0);
                    send_item(CH_COLON, 1'b0);
                    repeat ($urandom_range(0, 6))
                        send_item(($urandom_range(0, 4) == 0) ? CH_COLON : rand_letter(),
                                  1'b0);
                    send_item(CH_RBRACE, 1'b0);
                end
                12, 13:  send_item(CH_NL, 1'b0);
                14:      send_item(8'($urandom_range(0, 255)), 1'b1);
                default:
                begin
                    repeat ($urandom_range(1, 8))
                        send_item(rand_letter(), 1'b0);
                end
            endcase
        end
    endtask

    // Arbitrary bytes, stray delimiters and truncated tokens
    task automatic test_noise(input int unsigned n_items);
        int unsigned stop_at;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: send_item(8'($urandom_range(0, 255)), 1'b0);
                4, 5, 6, 7:
                begin
                    case ($urandom_range(0, 6))
                        0:       send_item(CH_SPACE, 1'b0);
                        1:       send_item(CH_LBRACE, 1'b0);
                        2:       send_item(CH_RBRACE, 1'b0);
                        3:       send_item(CH_LBRACK, 1'b0);
                        4:       send_item(CH_RBRACK, 1'b0);
                        5:       send_item(CH_COLON, 1'b0);
                        default: send_item(CH_NL, 1'b0);
                    endcase
                end
                8:       send_item(rand_letter(), 1'b0);
                default: send_item(8'($urandom_range(0, 255)), 1'b1);
            endcase
        end
    endtask

    // Result side: stall at random and compare each transaction with the oldest prediction
    always @(posedge clk)
    begin
        cpl_pkg::result_t want;
        cpl_pkg::result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind     = m_tdata[2:0];
            got.appended = m_tdata[3];
            got.lexeme   = m_tdata[11:4];
            got.ended    = m_tlast;
            got.bad      = m_tuser;
            if (token_results_q.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result kind=%0d app=%b byte=%h end=%b bad=%b",
                         $realtime, got.kind, got.appended, got.lexeme, got.ended, got.bad);
            end
            else
            begin
                want = token_results_q.pop_front();
                if (got !== want || m_tdata[15:12] !== 4'd0)
                begin
                    error_count++;
                    $display("%0t: expected kind=%0d app=%b byte=%h end=%b bad=%b pad=0",
                             $realtime, want.kind, want.appended, want.lexeme, want.ended,
                             want.bad);
                    $display("%0t: actual   kind=%0d app=%b byte=%h end=%b bad=%b pad=%h",
                             $realtime, got.kind, got.appended, got.lexeme, got.ended,
                             got.bad, m_tdata[15:12]);
                end
            end
        end
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    initial
    begin
        int unsigned src_pct[4];
        int unsigned sink_pct[4];
        src_pct  = '{0, 84, 0, 33};
        sink_pct = '{0, 0, 84, 33};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        for (int p = 0; p < 4; p++)
        begin
            src_idle_pct   = src_pct[p];
            sink_stall_pct = sink_pct[p];
            test_songs(300);
            test_noise(160);
        end
        s_tvalid <= 1'b0;
        while (token_results_q.size() != 0)
            @(posedge clk);
        // allow for the two-stage pipeline to flush any stray result
        repeat (6) @(posedge clk);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### sim.f
rtl/core/cpl_pkg.sv
rtl/core/cpl_classify.sv
rtl/core/cpl_step.sv
rtl/core/chordpro_lexer.sv
tb/sv/tb_chordpro_lexer.sv
